// ----- rtl/obstacle_avoid_motion_fsm_unit_assert.svh -----
// Assertion macros shared by the obstacle avoidance motion unit.
// No dependencies; the macros become empty when SYNTHESIS is defined.
`ifndef OBSTACLE_AVOID_MOTION_FSM_UNIT_ASSERT_SVH
`define OBSTACLE_AVOID_MOTION_FSM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define OAM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define OAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define OAM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define OAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/oam_pkg.sv -----
// Types and codes for the obstacle avoidance motion unit.
// No dependencies; used by every module of the block.
package oam_pkg;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_BUTTON = 2'd2;
	localparam logic [1:0] FUNC_BUMPER = 2'd3;

	localparam logic KIND_MOTION = 1'b0;
	localparam logic KIND_SOUND  = 1'b1;

	localparam logic [1:0] LED_BLACK  = 2'd0;
	localparam logic [1:0] LED_ORANGE = 2'd1;
	localparam logic [1:0] LED_RED    = 2'd2;

	localparam logic [2:0] CFG_FWD_SPEED         = 3'd0;
	localparam logic [2:0] CFG_TURN_RATE         = 3'd1;
	localparam logic [2:0] CFG_OBST_RANGE        = 3'd2;
	localparam logic [2:0] CFG_TURN_TICKS        = 3'd3;
	localparam logic [2:0] CFG_REORIENT_TICKS    = 3'd4;
	localparam logic [2:0] CFG_ARCH_TICKS        = 3'd5;
	localparam logic [2:0] CFG_RIGHT_SECTOR_END  = 3'd6;
	localparam logic [2:0] CFG_LEFT_SECTOR_START = 3'd7;

	localparam int SECTOR_W = 11;

	typedef enum logic [4:0] {
		MODE_FORWARD = 5'b00001,
		MODE_STOP    = 5'b00010,
		MODE_TURN    = 5'b00100,
		MODE_ARCH    = 5'b01000,
		MODE_REOR    = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [14:0]         fwd_speed;
		logic [14:0]         turn_rate;
		logic [15:0]         obst_range;
		logic [15:0]         turn_ticks;
		logic [15:0]         reorient_ticks;
		logic [15:0]         arch_ticks;
		logic [SECTOR_W-1:0] right_sector_end;
		logic [SECTOR_W-1:0] left_sector_start;
	} cfg_t;

	// Register values after reset: everything zero except the left sector start.
	localparam cfg_t CFG_RESET = '{
		fwd_speed:         15'd0,
		turn_rate:         15'd0,
		obst_range:        16'd0,
		turn_ticks:        16'd0,
		reorient_ticks:    16'd0,
		arch_ticks:        16'd0,
		right_sector_end:  11'd0,
		left_sector_start: 11'd1024
	};

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] range_mm;
		logic        range_valid;
		logic        sample_last;
		logic        button_down;
	} item_t;

	typedef struct packed {
		logic detect;
		logic min_right;
	} scan_stat_t;

	typedef struct packed {
		logic               kind;
		logic [14:0]        linear_cmd;
		logic signed [15:0] angular_cmd;
		logic [1:0]         led_colour;
	} res_t;

endpackage

// ----- rtl/oam_scan.sv -----
// Scan accumulator: nearest obstacle in the right and left front sectors.
// Depends on oam_pkg.
module oam_scan #(
	parameter int MAX_SCAN_POINTS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  oam_pkg::item_t      item,
	input  oam_pkg::cfg_t       cfg,
	output oam_pkg::scan_stat_t scan
);

	localparam int IDX_W = $clog2(MAX_SCAN_POINTS + 1);
	localparam int CMP_W = (IDX_W > oam_pkg::SECTOR_W) ? IDX_W : oam_pkg::SECTOR_W;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SCAN_POINTS);

	logic [IDX_W-1:0] idx_q;
	logic             det_q;
	logic [15:0]      min_q;
	logic             right_q;
	oam_pkg::scan_stat_t scan_q;

	logic [CMP_W-1:0] idx_x;
	logic             in_span;
	logic             hit;
	logic             det_r, right_r, det_l, right_l;
	logic [15:0]      min_r, min_l;

	always_comb begin
		idx_x   = CMP_W'(idx_q);
		in_span = idx_q < IDX_MAX;
		hit     = in_span && item.range_valid && (item.range_mm < cfg.obst_range);
		det_r   = det_q;
		min_r   = min_q;
		right_r = right_q;
		if (hit && (idx_x < CMP_W'(cfg.right_sector_end)) &&
		    (!det_q || (item.range_mm < min_q) || ((item.range_mm == min_q) && !right_q))) begin
			det_r   = 1'b1;
			min_r   = item.range_mm;
			right_r = 1'b1;
		end
		det_l   = det_r;
		min_l   = min_r;
		right_l = right_r;
		// A left-sector sample must be strictly nearer to replace the current minimum.
		if (hit && (idx_x >= CMP_W'(cfg.left_sector_start)) &&
		    (!det_r || (item.range_mm < min_r))) begin
			det_l   = 1'b1;
			min_l   = item.range_mm;
			right_l = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			det_q   <= 1'b0;
			min_q   <= '1;
			right_q <= 1'b0;
			scan_q  <= '0;
		end else if (fire && (item.func == oam_pkg::FUNC_SAMPLE)) begin
			if (item.sample_last) begin
				scan_q.detect    <= det_l;
				scan_q.min_right <= right_l;
				idx_q            <= '0;
				det_q            <= 1'b0;
				min_q            <= '1;
				right_q          <= 1'b0;
			end else begin
				det_q   <= det_l;
				min_q   <= min_l;
				right_q <= right_l;
				if (in_span) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	assign scan = scan_q;

endmodule

// ----- rtl/oam_motion.sv -----
// Mode machine, run flag and tick counters; forms at most one result per item.
// Depends on oam_pkg.
module oam_motion #(
	parameter int SCAN_TIMEOUT_TICKS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  oam_pkg::item_t      item,
	input  oam_pkg::cfg_t       cfg,
	input  oam_pkg::scan_stat_t scan,
	output logic                res_valid,
	output oam_pkg::res_t       res
);

	localparam logic [15:0] TIMEOUT = 16'(SCAN_TIMEOUT_TICKS);

	oam_pkg::mode_t mode_q, mode_n;
	logic        running_q, running_n;
	logic        side_left_q, side_left_n;
	logic        have_scan_q, have_scan_n;
	logic [15:0] mode_ticks_q, mode_ticks_n;
	logic [15:0] age_q, age_n;

	logic [15:0]        mt;
	logic signed [15:0] ang_side;

	always_comb begin
		mode_n       = mode_q;
		running_n    = running_q;
		side_left_n  = side_left_q;
		have_scan_n  = have_scan_q;
		mode_ticks_n = mode_ticks_q;
		age_n        = age_q;
		res_valid    = 1'b0;
		res          = '0;
		mt           = (mode_ticks_q == 16'hFFFF) ? mode_ticks_q : mode_ticks_q + 16'd1;
		ang_side     = side_left_q ? $signed({1'b0, cfg.turn_rate})
		                           : -$signed({1'b0, cfg.turn_rate});
		if (fire) begin
			unique case (item.func)
				oam_pkg::FUNC_SAMPLE: begin
					if (item.sample_last) begin
						have_scan_n = 1'b1;
						age_n       = '0;
					end
				end
				oam_pkg::FUNC_BUTTON: begin
					if (item.button_down) begin
						running_n = !running_q;
					end
				end
				oam_pkg::FUNC_BUMPER: begin
					running_n = 1'b0;
					res_valid = 1'b1;
					res.kind  = oam_pkg::KIND_SOUND;
				end
				oam_pkg::FUNC_TICK: begin
					mode_ticks_n = mt;
					if (have_scan_q && (age_q != 16'hFFFF)) begin
						age_n = age_q + 16'd1;
					end
					if (have_scan_q && running_q) begin
						res_valid = 1'b1;
						res.kind  = oam_pkg::KIND_MOTION;
						unique case (mode_q)
							oam_pkg::MODE_FORWARD: begin
								res.linear_cmd = cfg.fwd_speed;
								if (age_n > TIMEOUT) begin
									res.linear_cmd = '0;
									mode_n         = oam_pkg::MODE_STOP;
									mode_ticks_n   = '0;
								end
								if (scan.detect) begin
									side_left_n  = !scan.min_right;
									mode_n       = oam_pkg::MODE_TURN;
									mode_ticks_n = '0;
								end
							end
							oam_pkg::MODE_TURN: begin
								res.angular_cmd = ang_side;
								if (mt > cfg.turn_ticks) begin
									mode_n       = oam_pkg::MODE_ARCH;
									mode_ticks_n = '0;
								end
							end
							oam_pkg::MODE_STOP: begin
								res.led_colour = oam_pkg::LED_ORANGE;
								if (age_n < TIMEOUT) begin
									mode_n       = oam_pkg::MODE_FORWARD;
									mode_ticks_n = '0;
								end
							end
							oam_pkg::MODE_REOR: begin
								res.angular_cmd = ang_side;
								if (mt > cfg.reorient_ticks) begin
									mode_n       = oam_pkg::MODE_FORWARD;
									mode_ticks_n = '0;
								end
							end
							oam_pkg::MODE_ARCH: begin
								res.led_colour  = oam_pkg::LED_RED;
								res.linear_cmd  = cfg.fwd_speed;
								res.angular_cmd = -ang_side;
								if ((cfg.fwd_speed == '0) || (mt >= cfg.arch_ticks)) begin
									mode_n       = oam_pkg::MODE_REOR;
									mode_ticks_n = '0;
								end else if (scan.detect) begin
									side_left_n  = !scan.min_right;
									mode_n       = oam_pkg::MODE_TURN;
									mode_ticks_n = '0;
								end
							end
							default: begin
								mode_n = oam_pkg::MODE_FORWARD;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= oam_pkg::MODE_FORWARD;
			running_q    <= 1'b0;
			side_left_q  <= 1'b1;
			have_scan_q  <= 1'b0;
			mode_ticks_q <= '0;
			age_q        <= '0;
		end else begin
			mode_q       <= mode_n;
			running_q    <= running_n;
			side_left_q  <= side_left_n;
			have_scan_q  <= have_scan_n;
			mode_ticks_q <= mode_ticks_n;
			age_q        <= age_n;
		end
	end

endmodule

// ----- rtl/obstacle_avoid_motion_fsm_unit.sv -----
// Obstacle avoidance motion unit: an accepted word passes through the input register, then
// the result register; one word is accepted every cycle while the input is not stalled.
// Words that cause no result (samples, button, unproductive ticks) still take their slot.
// Reset (arst_n low, asynchronous) clears all control state and loads the register defaults.
// Depends on oam_pkg, oam_scan, oam_motion and the assertion macro header.
`include "obstacle_avoid_motion_fsm_unit_assert.svh"
module obstacle_avoid_motion_fsm_unit #(
	parameter int MAX_SCAN_POINTS    = 1024,
	parameter int SCAN_TIMEOUT_TICKS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [15:0]        range_mm,
	input  logic               range_valid,
	input  logic               sample_last,
	input  logic               button_down,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [14:0]        linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic [1:0]         led_colour,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// Configuration registers. Writes are always taken; the user writes only while idle.
	oam_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= oam_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				oam_pkg::CFG_FWD_SPEED:         cfg_q.fwd_speed         <= cfg_data[14:0];
				oam_pkg::CFG_TURN_RATE:         cfg_q.turn_rate         <= cfg_data[14:0];
				oam_pkg::CFG_OBST_RANGE:        cfg_q.obst_range        <= cfg_data;
				oam_pkg::CFG_TURN_TICKS:        cfg_q.turn_ticks        <= cfg_data;
				oam_pkg::CFG_REORIENT_TICKS:    cfg_q.reorient_ticks    <= cfg_data;
				oam_pkg::CFG_ARCH_TICKS:        cfg_q.arch_ticks        <= cfg_data;
				oam_pkg::CFG_RIGHT_SECTOR_END:  cfg_q.right_sector_end  <= cfg_data[10:0];
				oam_pkg::CFG_LEFT_SECTOR_START: cfg_q.left_sector_start <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// Stage one holds the accepted word. It moves on whenever the result register is
	// empty or its word is being taken this cycle, so the input only stalls when the
	// result side is stalled with a word waiting and another word sits in stage one.
	oam_pkg::item_t item_s1;
	logic           valid_s1;
	logic           advance;
	logic           fire;

	assign advance  = !out_valid || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1.func        <= func;
			item_s1.range_mm    <= range_mm;
			item_s1.range_valid <= range_valid;
			item_s1.sample_last <= sample_last;
			item_s1.button_down <= button_down;
		end
	end

	// The scan accumulator and the mode machine both act on the stage-one word in the
	// cycle it fires. The committed scan status is a register, so a tick always sees
	// the scan completed by earlier words.
	oam_pkg::scan_stat_t scan;
	logic                res_valid;
	oam_pkg::res_t       res;

	oam_scan #(
		.MAX_SCAN_POINTS(MAX_SCAN_POINTS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.cfg   (cfg_q),
		.scan  (scan)
	);

	oam_motion #(
		.SCAN_TIMEOUT_TICKS(SCAN_TIMEOUT_TICKS)
	) u_motion (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg      (cfg_q),
		.scan     (scan),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register. It loads whenever stage one may advance; a firing word that
	// makes no result leaves it empty, and an idle cycle empties it once taken.
	logic          out_valid_q;
	oam_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign linear_cmd  = res_q.linear_cmd;
	assign angular_cmd = res_q.angular_cmd;
	assign led_colour  = res_q.led_colour;

	// The input may only stall while the result side holds a blocked word.
	`OAM_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	// A bumper sound word carries no motion.
	`OAM_ASSERT_IMPLIES(a_sound_quiet, clk, arst_n, out_valid && (kind == oam_pkg::KIND_SOUND),
		(linear_cmd == '0) && (angular_cmd == '0) && (led_colour == oam_pkg::LED_BLACK))
	// Red LED means arch, which drives the configured forward speed.
	`OAM_ASSERT_IMPLIES(a_arch_speed, clk, arst_n, out_valid && (led_colour == oam_pkg::LED_RED),
		linear_cmd == cfg_q.fwd_speed)
	// A word taken from stage one with a result shows up in the next cycle.
	`OAM_ASSERT_NEXT(a_result_next, clk, arst_n, fire && res_valid, out_valid)

endmodule

// ----- tb/oam_motion_checker.sv -----
// Scoreboard for the obstacle avoidance motion unit: follows the input, result and register
// write channels, keeps its own copy of the scan and mode state, and checks every result word.
// Depends on oam_pkg for the codes, the mode enum and the register and result structs.
`timescale 1ns / 1ps
module oam_motion_checker #(
	parameter int MAX_SCAN_POINTS    = 1024,
	parameter int SCAN_TIMEOUT_TICKS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic [15:0]        range_mm,
	input  logic               range_valid,
	input  logic               sample_last,
	input  logic               button_down,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               kind,
	input  logic [14:0]        linear_cmd,
	input  logic signed [15:0] angular_cmd,
	input  logic [1:0]         led_colour,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 words_seen,
	output int                 results_seen,
	output int                 sounds_seen,
	output int                 scans_seen,
	output int                 turns_seen
);
	import oam_pkg::*;

	cfg_t        regs;
	mode_t       mode;
	logic        running, side_left, have_scan;
	logic [15:0] mode_ticks, scan_age;
	logic [10:0] samp_idx;
	logic        acc_detect, acc_right, scan_detect, scan_right;
	logic [15:0] acc_min;
	res_t        due_cmds[$];

	task automatic clear_scan_acc();
		samp_idx   = '0;
		acc_detect = 1'b0;
		acc_min    = 16'hFFFF;
		acc_right  = 1'b0;
	endtask

	task automatic reset_model();
		regs                   = '0;
		regs.left_sector_start = 11'd1024;
		mode                   = MODE_FORWARD;
		running                = 1'b0;
		side_left              = 1'b1;
		mode_ticks             = '0;
		scan_age               = '0;
		have_scan              = 1'b0;
		scan_detect            = 1'b0;
		scan_right             = 1'b0;
		clear_scan_acc();
	endtask

	function automatic logic [15:0] inc_sat(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	task automatic change_mode(mode_t m);
		mode       = m;
		mode_ticks = '0;
		if (m == MODE_TURN)
			turns_seen++;
	endtask

	// Looking at the committed scan also re-aims the turn toward the free side.
	task automatic check_obstacle(output logic hit);
		if (scan_detect)
			side_left = !scan_right;
		hit = scan_detect;
	endtask

	task automatic take_sample(logic [15:0] r, logic ok, logic last);
		if (samp_idx < MAX_SCAN_POINTS) begin
			if (ok && r < regs.obst_range) begin
				// The right sector is scanned first and keeps ties against any left copy.
				if (samp_idx < regs.right_sector_end &&
				    (!acc_detect || r < acc_min || (r == acc_min && !acc_right))) begin
					acc_detect = 1'b1;
					acc_min    = r;
					acc_right  = 1'b1;
				end
				if (samp_idx >= regs.left_sector_start && (!acc_detect || r < acc_min)) begin
					acc_detect = 1'b1;
					acc_min    = r;
					acc_right  = 1'b0;
				end
			end
			samp_idx++;
		end
		if (last) begin
			scan_detect = acc_detect;
			scan_right  = acc_right;
			have_scan   = 1'b1;
			scan_age    = '0;
			scans_seen++;
			clear_scan_acc();
		end
	endtask

	task automatic control_tick(output logic emit, output res_t cmd);
		logic signed [15:0] rate, toward;
		logic               hit;
		emit       = 1'b0;
		cmd        = '0;
		mode_ticks = inc_sat(mode_ticks);
		if (have_scan)
			scan_age = inc_sat(scan_age);
		if (have_scan && running) begin
			rate            = signed'({1'b0, regs.turn_rate});
			toward          = side_left ? rate : -rate;
			emit            = 1'b1;
			cmd.kind        = KIND_MOTION;
			cmd.led_colour  = LED_BLACK;
			case (mode)
			MODE_FORWARD: begin
				cmd.linear_cmd = regs.fwd_speed;
				if (scan_age > SCAN_TIMEOUT_TICKS) begin
					cmd.linear_cmd = '0;
					change_mode(MODE_STOP);
				end
				check_obstacle(hit);
				if (hit)
					change_mode(MODE_TURN);
			end
			MODE_TURN: begin
				cmd.angular_cmd = toward;
				if (mode_ticks > regs.turn_ticks)
					change_mode(MODE_ARCH);
			end
			MODE_STOP: begin
				cmd.led_colour = LED_ORANGE;
				if (scan_age < SCAN_TIMEOUT_TICKS)
					change_mode(MODE_FORWARD);
			end
			MODE_REOR: begin
				cmd.angular_cmd = toward;
				if (mode_ticks > regs.reorient_ticks)
					change_mode(MODE_FORWARD);
			end
			default: begin
				cmd.led_colour  = LED_RED;
				cmd.linear_cmd  = regs.fwd_speed;
				cmd.angular_cmd = -toward;
				if (regs.fwd_speed == '0 || mode_ticks >= regs.arch_ticks) begin
					change_mode(MODE_REOR);
				end else begin
					check_obstacle(hit);
					if (hit)
						change_mode(MODE_TURN);
				end
			end
			endcase
		end
	endtask

	task automatic step_controller();
		logic emit;
		res_t cmd;
		case (func)
		FUNC_SAMPLE: take_sample(range_mm, range_valid, sample_last);
		FUNC_BUTTON: begin
			if (button_down)
				running = !running;
		end
		FUNC_BUMPER: begin
			running = 1'b0;
			cmd     = '0;
			cmd.kind = KIND_SOUND;
			due_cmds.push_back(cmd);
		end
		FUNC_TICK: begin
			control_tick(emit, cmd);
			if (emit)
				due_cmds.push_back(cmd);
		end
		endcase
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
		CFG_FWD_SPEED:         regs.fwd_speed         = val[14:0];
		CFG_TURN_RATE:         regs.turn_rate         = val[14:0];
		CFG_OBST_RANGE:        regs.obst_range        = val;
		CFG_TURN_TICKS:        regs.turn_ticks        = val;
		CFG_REORIENT_TICKS:    regs.reorient_ticks    = val;
		CFG_ARCH_TICKS:        regs.arch_ticks        = val;
		CFG_RIGHT_SECTOR_END:  regs.right_sector_end  = val[SECTOR_W-1:0];
		CFG_LEFT_SECTOR_START: regs.left_sector_start = val[SECTOR_W-1:0];
		endcase
	endtask

	// Field values are printed in the order kind, linear, angular, LED.
	task automatic check_result();
		res_t want, got;
		got.kind        = kind;
		got.linear_cmd  = linear_cmd;
		got.angular_cmd = angular_cmd;
		got.led_colour  = led_colour;
		results_seen++;
		if (got.kind == KIND_SOUND)
			sounds_seen++;
		if (due_cmds.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: word %0d arrived with nothing due: %0d/%0d/%0d/%0d",
					$time, results_seen, got.kind, got.linear_cmd, got.angular_cmd,
					got.led_colour);
		end else begin
			want = due_cmds.pop_front();
			if (got.kind !== want.kind || got.linear_cmd !== want.linear_cmd ||
			    got.angular_cmd !== want.angular_cmd || got.led_colour !== want.led_colour) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: word %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$time, results_seen, want.kind, want.linear_cmd, want.angular_cmd,
						want.led_colour, got.kind, got.linear_cmd, got.angular_cmd,
						got.led_colour);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			due_cmds.delete();
			fail_count   = 0;
			words_seen   = 0;
			results_seen = 0;
			sounds_seen  = 0;
			scans_seen   = 0;
			turns_seen   = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				words_seen++;
				step_controller();
			end
			if (out_valid && !out_stall)
				check_result();
		end
		pending = due_cmds.size();
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench for the obstacle avoidance motion unit: clock, reset, register
// setup, input stimulus, output stalls, watchdog and verdict. Needs oam_pkg, the unit
// and oam_motion_checker, which predicts and checks every result word.
`timescale 1ns / 1ps
module testbench;
	import oam_pkg::*;

	// The unit answers once a word has passed its input and result registers, so DRAIN_CYCLES
	// is plenty for words that produce nothing to drain before registers are touched.
	localparam int DRAIN_CYCLES = 6;
	// Cycles without any handshake on any channel before the run is declared hung.
	localparam int QUIET_LIMIT  = 5000;
	// Length of the deliberate result-side hold-off that backs the pipeline up.
	localparam int HOLD_CYCLES  = 300;
	// A short scan limit keeps the overlong scan cheap to send.
	localparam int SCAN_POINTS  = 16;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [15:0]        range_mm;
	logic               range_valid;
	logic               sample_last;
	logic               button_down;
	logic               out_valid;
	logic               out_stall;
	logic               kind;
	logic [14:0]        linear_cmd;
	logic signed [15:0] angular_cmd;
	logic [1:0]         led_colour;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	int fail_count, pending, words_seen, results_seen, sounds_seen, scans_seen, turns_seen;

	// Stimulus-side bookkeeping. The running flag is tracked only to decide when to press
	// the button; it is never used to predict results.
	int          send_idle_pct;
	int          recv_idle_pct;
	int          n_sent;
	logic        running_on;
	logic        hold_req;
	logic [15:0] cur_od;

	obstacle_avoid_motion_fsm_unit #(
		.MAX_SCAN_POINTS(SCAN_POINTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.range_mm    (range_mm),
		.range_valid (range_valid),
		.sample_last (sample_last),
		.button_down (button_down),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.led_colour  (led_colour),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	oam_motion_checker #(
		.MAX_SCAN_POINTS(SCAN_POINTS)
	) motion_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.range_mm     (range_mm),
		.range_valid  (range_valid),
		.sample_last  (sample_last),
		.button_down  (button_down),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.linear_cmd   (linear_cmd),
		.angular_cmd  (angular_cmd),
		.led_colour   (led_colour),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_seen   (words_seen),
		.results_seen (results_seen),
		.sounds_seen  (sounds_seen),
		.scans_seen   (scans_seen),
		.turns_seen   (turns_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side. A pending hold request wins and keeps the stall up for a long stretch
	// while the sender keeps offering words, so the unit fills and pushes back on its
	// input. Otherwise the stall is random at the current idle rate.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// The watchdog restarts its count on any handshake and ends the run when the count
	// runs out, which only happens if the unit hangs or drops a word.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	// Offers one word and returns at the clock edge where it is taken. Stall is looked at
	// on the falling edge, where every signal has settled, so the test does not depend on
	// the order of events at the rising edge.
	task automatic send_word(input logic [1:0] f, input logic [15:0] r, input logic ok,
		input logic last, input logic btn);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		range_mm    <= r;
		range_valid <= ok;
		sample_last <= last;
		button_down <= btn;
		if (f == FUNC_BUTTON && btn)
			running_on = !running_on;
		if (f == FUNC_BUMPER)
			running_on = 1'b0;
		n_sent++;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Ticks, buttons and bumpers carry random junk in the fields they do not use.
	task automatic tick();
		send_word(FUNC_TICK, 16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic press(input logic btn);
		send_word(FUNC_BUTTON, 16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
			btn);
	endtask

	task automatic bump();
		send_word(FUNC_BUMPER, 16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic sample(input logic [15:0] r, input logic ok, input logic last);
		send_word(FUNC_SAMPLE, r, ok, last, 1'($urandom_range(1)));
	endtask

	// Ranges lean toward the interesting ones: exactly at and just under the threshold,
	// a repeated value that makes ties, and the two ends of the field.
	function automatic logic [15:0] pick_range(input logic [15:0] od, input logic [15:0] tie);
		case ($urandom_range(9))
		0, 1: return 16'($urandom);
		2: return od;
		3: return od - 16'd1;
		4, 5: return tie;
		6: return 16'd0;
		7: return 16'hFFFF;
		default: return (od == 0) ? 16'($urandom) : 16'($urandom_range(0, od - 1));
		endcase
	endfunction

	task automatic send_scan(input int len, input logic [15:0] od);
		logic [15:0] tie;
		tie = (od == 0) ? 16'($urandom) : 16'($urandom_range(0, od - 1));
		for (int k = 0; k < len; k++)
			sample(pick_range(od, tie), $urandom_range(9) != 0, k == len - 1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Registers are only written once the unit has gone quiet: every due result word is
	// back and the last words that produce nothing have had time to leave the pipeline.
	task automatic load_settings(input logic [15:0] sl, input logic [15:0] sa,
		input logic [15:0] od, input logic [15:0] tt, input logic [15:0] rt,
		input logic [15:0] at, input logic [15:0] rse, input logic [15:0] lss);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_FWD_SPEED, sl);
		write_reg(CFG_TURN_RATE, sa);
		write_reg(CFG_OBST_RANGE, od);
		write_reg(CFG_TURN_TICKS, tt);
		write_reg(CFG_REORIENT_TICKS, rt);
		write_reg(CFG_ARCH_TICKS, at);
		write_reg(CFG_RIGHT_SECTOR_END, rse);
		write_reg(CFG_LEFT_SECTOR_START, lss);
		cfg_valid <= 1'b0;
		cur_od = od;
	endtask

	task automatic random_settings();
		load_settings(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
			16'($urandom_range(500, 40000)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
			16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
	endtask

	// Most of the traffic is whole scans and tick bursts while running, since that is what
	// drives the mode machine through its states. The rest is button and bumper events,
	// long lulls that let the scan go stale, scans cut short by a tick, and raw noise.
	task automatic run_random(input int n);
		int   stop, pick;
		logic lull;
		stop = n_sent + n;
		while (n_sent < stop) begin
			pick = $urandom_range(99);
			if (!running_on && pick < 50) begin
				press(1'b1);
			end else if (pick < 40) begin
				send_scan($urandom_range(1, 14), cur_od);
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 6)) tick();
			end else if (pick < 76) begin
				// Pausing across the lull lets the scan age past the timeout while the
				// machine sits still, so the next run tick can see stop and obstacle at once.
				lull = 1'($urandom_range(1));
				if (lull && running_on)
					press(1'b1);
				repeat ($urandom_range(21, 26)) tick();
				if (lull)
					press(1'b1);
			end else if (pick < 82) begin
				press(1'($urandom_range(1)));
			end else if (pick < 86) begin
				bump();
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 5))
					sample(pick_range(cur_od, cur_od >> 1), 1'($urandom_range(1)), 1'b0);
				tick();
			end else begin
				send_word(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin : stimulus
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		func            = FUNC_TICK;
		range_mm        = '0;
		range_valid     = 1'b0;
		sample_last     = 1'b0;
		button_down     = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_FWD_SPEED;
		cfg_data        = '0;
		hold_req        = 1'b0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		n_sent          = 0;
		running_on      = 1'b0;
		cur_od          = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Full speeds, a threshold of 1000, and sectors that overlap at
		// sample 2, so sample 2 counts for the right and the left side alike.
		load_settings(16'd32767, 16'd32767, 16'd1000, 16'd1, 16'd0, 16'd2, 16'd3, 16'd2);
		tick();                      // no scan yet: only the counters move
		bump();                      // error sound even while stopped
		press(1'b0);                 // a release does nothing
		press(1'b1);                 // running on
		tick();                      // running, but still no scan
		sample(16'hFFFF, 1'b1, 1'b0);
		sample(16'd0, 1'b0, 1'b0);   // an invalid zero must not count
		sample(16'd1000, 1'b1, 1'b0);// exactly at the threshold is not an obstacle
		sample(16'd500, 1'b1, 1'b1); // left sector only: the scan says turn left
		tick();                      // forward sees the obstacle and starts turning
		tick();
		tick();                      // turn time is over: into the arch
		sample(16'd0, 1'b1, 1'b0);
		sample(16'd9, 1'b1, 1'b0);
		sample(16'd0, 1'b1, 1'b1);   // tie in the overlap: the right copy holds
		tick();                      // a new obstacle during the arch turns again
		sample(16'd800, 1'b1, 1'b0);
		sample(16'd300, 1'b1, 1'b0);
		sample(16'd300, 1'b1, 1'b0);
		sample(16'd300, 1'b1, 1'b1); // equal left copy loses to the earlier right one
		repeat (3) tick();
		bump();
		press(1'b1);

		// Random part, first with a slow receiver and then with a slow sender.
		send_idle_pct = 25;
		recv_idle_pct = 83;
		load_settings(16'd120, 16'd300, 16'd2000, 16'd2, 16'd1, 16'd3, 16'd4, 16'd6);
		run_random(84);
		// Zero speeds end every arch at once; the top threshold makes nearly all ranges
		// obstacles, and the whole scan lies in the left sector.
		load_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(84);

		send_idle_pct = 83;
		recv_idle_pct = 25;
		// A zero threshold means nothing is ever an obstacle; the right sector covers every sample.
		load_settings(16'd32767, 16'd1, 16'd0, 16'd3, 16'd2, 16'd5, 16'd1024, 16'd1024);
		run_random(84);
		random_settings();
		run_random(84);

		// No idling from here on. The first window also backs the pipeline up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_settings(16'd5, 16'd32767, 16'd30000, 16'd1, 16'd3, 16'd1, 16'd8, 16'd4);
		if (!running_on)
			press(1'b1);
		send_scan(3, cur_od);
		hold_req = 1'b1;
		run_random(84);
		random_settings();
		run_random(84);

		// One scan longer than the unit takes in: samples past the end are dropped, yet
		// the last one still commits the scan.
		load_settings(16'd200, 16'd400, 16'd800, 16'd1, 16'd1, 16'd2, 16'd16, 16'd12);
		if (!running_on)
			press(1'b1);
		send_scan(SCAN_POINTS + 4, cur_od);
		repeat (8) tick();

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d input words, %0d scans and %0d entries into the turn.",
			words_seen, scans_seen, turns_seen);
		$display("It checked %0d result words, %0d of them error sounds; %0d mismatches.",
			results_seen, sounds_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
